### rtl/i2cee_pkg.sv
// ----------------------------------------------------------------------------
// i2cee_pkg
// Shared constants, action codes and controller/datapath interface types for
// the EEPROM-style I2C slave memory.
// ----------------------------------------------------------------------------
package i2cee_pkg;

    localparam int MEM_DEPTH = 64;
    localparam int PTR_W     = $clog2(MEM_DEPTH);
    localparam int ACT_W     = 2;
    localparam int DATA_W    = 8;
    localparam int SEEN_W    = 2;
    localparam int OUT_PTR_W = 6;

    localparam logic [ACT_W-1:0] ACT_WR_ADDR = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DATA    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RD_ADDR = 2'd2;
    localparam logic [ACT_W-1:0] ACT_RD_REQ  = 2'd3;

    localparam logic [SEEN_W-1:0] ADDR_BYTES = 2'd2;

    typedef struct packed {
        logic load;    // capture the input transfer
        logic exec;    // apply the event to pointer, address state and memory
        logic resp;    // move the result into the output register
    } cmd_t;

    typedef struct packed {
        logic out_blocked;  // output register holds a result that is not taken
    } stat_t;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(MEM_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

endpackage

### rtl/i2c_eeprom_style_slave_memory.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_style_slave_memory
// EEPROM-style 64-byte memory behind already-decoded I2C slave byte events.
// ----------------------------------------------------------------------------
// Each event passes through three steps: accept, execute (pointer update,
// memory write or registered memory read), and load into the output register,
// which holds while the previous result is not taken; the next event is
// accepted in the cycle after the load, so no new event is taken before the
// last one is loaded. One result comes out per event. A write-direction address
// event resets the pointer; the next two data bytes are the word address
// (high byte dropped, low byte modulo 64), applied once at the next stored
// data byte or read-direction address event. Memory reads as zero after reset.
module i2c_eeprom_style_slave_memory
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [i2cee_pkg::ACT_W-1:0]     action,
    input  logic [i2cee_pkg::DATA_W-1:0]    data_in,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [i2cee_pkg::DATA_W-1:0]    read_data,
    output logic                            read_valid,
    output logic [i2cee_pkg::OUT_PTR_W-1:0] pointer_now
);
    import i2cee_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    i2cee_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    i2cee_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .action      (action),
        .data_in     (data_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_data   (read_data),
        .read_valid  (read_valid),
        .pointer_now (pointer_now)
    );

endmodule

### rtl/i2cee_ctrl.sv
// ----------------------------------------------------------------------------
// i2cee_ctrl
// Sequencer: accept one event, execute it, then hand the result to the output
// register.
// ----------------------------------------------------------------------------
module i2cee_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  i2cee_pkg::stat_t stat,
    output i2cee_pkg::cmd_t  cmd
);
    import i2cee_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                // hold until the previous result is taken
                if (!stat.out_blocked)
                begin
                    cmd.resp   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/i2cee_dp.sv
// ----------------------------------------------------------------------------
// i2cee_dp
// Datapath: event registers, word-address collection, pointer, byte memory
// with per-entry valid bits, and the output register.
// ----------------------------------------------------------------------------
module i2cee_dp
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  i2cee_pkg::cmd_t                 cmd,
    output i2cee_pkg::stat_t                stat,
    input  logic [i2cee_pkg::ACT_W-1:0]     action,
    input  logic [i2cee_pkg::DATA_W-1:0]    data_in,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [i2cee_pkg::DATA_W-1:0]    read_data,
    output logic                            read_valid,
    output logic [i2cee_pkg::OUT_PTR_W-1:0] pointer_now
);
    import i2cee_pkg::*;

    logic [ACT_W-1:0]  act_reg;
    logic [DATA_W-1:0] data_reg;

    logic [PTR_W-1:0]  pointer_reg;
    logic [PTR_W-1:0]  pointer_next;
    logic [SEEN_W-1:0] seen_reg;
    logic [SEEN_W-1:0] seen_next;
    logic [PTR_W-1:0]  addr_low_reg;
    logic [PTR_W-1:0]  addr_low_next;
    logic              pend_reg;
    logic              pend_next;

    logic [PTR_W-1:0]  start_ptr;
    logic              wr_en;

    logic [DATA_W-1:0] mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] written_reg;
    logic [DATA_W-1:0] rd_q;
    logic              rd_hit_q;

    logic              out_valid_reg;
    logic [DATA_W-1:0] read_data_reg;
    logic              read_valid_reg;
    logic [OUT_PTR_W-1:0] pointer_now_reg;

    // event capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg  <= action;
            data_reg <= data_in;
        end
    end

    // a pending start address replaces the pointer once
    assign start_ptr = pend_reg ? addr_low_reg : pointer_reg;

    always_comb
    begin
        pointer_next  = pointer_reg;
        seen_next     = seen_reg;
        addr_low_next = addr_low_reg;
        pend_next     = pend_reg;
        wr_en         = 1'b0;
        unique case (act_reg)
            ACT_WR_ADDR:
            begin
                pointer_next  = '0;
                seen_next     = '0;
                addr_low_next = '0;
                pend_next     = 1'b0;
            end
            ACT_DATA:
            begin
                if (seen_reg < ADDR_BYTES)
                begin
                    // first byte is the high address byte and is dropped
                    if (seen_reg == SEEN_W'(1))
                    begin
                        addr_low_next = data_reg[PTR_W-1:0];
                        pend_next     = 1'b1;
                    end
                    seen_next = seen_reg + SEEN_W'(1);
                end
                else
                begin
                    wr_en        = 1'b1;
                    pointer_next = next_slot(start_ptr);
                    pend_next    = 1'b0;
                end
            end
            ACT_RD_ADDR:
            begin
                pointer_next = start_ptr;
                pend_next    = 1'b0;
            end
            ACT_RD_REQ:
            begin
                pointer_next = next_slot(pointer_reg);
            end
            default:
            begin
                pointer_next = pointer_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pointer_reg  <= '0;
            seen_reg     <= '0;
            addr_low_reg <= '0;
            pend_reg     <= 1'b0;
        end
        else if (cmd.exec)
        begin
            pointer_reg  <= pointer_next;
            seen_reg     <= seen_next;
            addr_low_reg <= addr_low_next;
            pend_reg     <= pend_next;
        end
    end

    // byte memory, registered read at the current pointer
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            if (wr_en)
            begin
                mem[start_ptr] <= data_reg;
            end
            rd_q <= mem[pointer_reg];
        end
    end

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rd_hit_q    <= 1'b0;
        end
        else if (cmd.exec)
        begin
            if (wr_en)
            begin
                written_reg[start_ptr] <= 1'b1;
            end
            rd_hit_q <= written_reg[pointer_reg];
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.resp)
        begin
            read_valid_reg  <= (act_reg == ACT_RD_REQ);
            read_data_reg   <= (act_reg == ACT_RD_REQ && rd_hit_q) ? rd_q : '0;
            pointer_now_reg <= OUT_PTR_W'(pointer_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.resp)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign stat.out_blocked = out_valid_reg && out_stall;
    assign out_valid        = out_valid_reg;
    assign read_data        = read_data_reg;
    assign read_valid       = read_valid_reg;
    assign pointer_now      = pointer_now_reg;

endmodule

### sim/i2c_eeprom_style_slave_memory_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_eeprom_style_slave_memory_tb
// Drives slave byte events into the EEPROM-style memory and checks every
// result transfer field by field against a typed result or an in-bench
// model of the pointer, word-address capture and 64-byte store. A short table
// of directed events comes first, followed by random write bursts, random and
// sequential reads and noise, with random idling and stalls on both channels.
// ----------------------------------------------------------------------------
module i2c_eeprom_style_slave_memory_tb;
    import i2cee_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0]    rdata;
        logic                 rvalid;
        logic [OUT_PTR_W-1:0] ptr;
    } event_result_t;

    typedef struct packed {
        logic [ACT_W-1:0]  act;
        logic [DATA_W-1:0] dat;
        logic              typed;
        event_result_t     exp;
    } stim_row_t;

    localparam int N_DIRECTED   = 25;
    localparam int N_RANDOM     = 900;
    localparam int PAUSE_AT     = 400;
    localparam int LONG_HOLD_AT = 300;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [ACT_W-1:0]     action;
    logic [DATA_W-1:0]    data_in;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [DATA_W-1:0]    read_data;
    logic                 read_valid;
    logic [OUT_PTR_W-1:0] pointer_now;

    // model state
    logic [DATA_W-1:0] mem_img [MEM_DEPTH];
    logic [PTR_W-1:0]  cur_ptr;
    logic [SEEN_W-1:0] addr_cnt;
    logic [DATA_W-1:0] addr_lo;
    logic              start_armed;

    event_result_t expected_q[$];
    int            err_cnt       = 0;
    int            items_sent    = 0;
    int            results_taken = 0;
    int            stall_left    = 0;
    int            hold_left     = 0;
    bit            long_done     = 1'b0;

    // Expected results are typed in only for reset reads and write-address events.
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{ACT_RD_REQ,  8'h00, 1'b1, '{8'h00, 1'b1, 6'd1}},  // read after reset
        '{ACT_DATA,    8'hAB, 1'b0, '0},                    // data before any address
        '{ACT_DATA,    8'h45, 1'b0, '0},
        '{ACT_DATA,    8'hFF, 1'b0, '0},
        '{ACT_WR_ADDR, 8'hC3, 1'b1, '{8'h00, 1'b0, 6'd0}},
        '{ACT_DATA,    8'hFF, 1'b0, '0},                    // high byte dropped
        '{ACT_DATA,    8'h3F, 1'b0, '0},
        '{ACT_DATA,    8'h00, 1'b0, '0},                    // store at the end, wrap
        '{ACT_DATA,    8'h5A, 1'b0, '0},
        '{ACT_WR_ADDR, 8'h00, 1'b1, '{8'h00, 1'b0, 6'd0}},
        '{ACT_DATA,    8'h00, 1'b0, '0},
        '{ACT_RD_REQ,  8'hFF, 1'b0, '0},                    // read between address bytes
        '{ACT_DATA,    8'h05, 1'b0, '0},
        '{ACT_RD_ADDR, 8'h7E, 1'b0, '0},
        '{ACT_RD_REQ,  8'h00, 1'b0, '0},
        '{ACT_RD_ADDR, 8'h00, 1'b0, '0},                    // nothing pending: sequential
        '{ACT_RD_REQ,  8'h00, 1'b0, '0},
        '{ACT_WR_ADDR, 8'h00, 1'b1, '{8'h00, 1'b0, 6'd0}},
        '{ACT_DATA,    8'h12, 1'b0, '0},
        '{ACT_DATA,    8'hFF, 1'b0, '0},                    // low byte beyond depth
        '{ACT_RD_ADDR, 8'h00, 1'b0, '0},
        '{ACT_RD_REQ,  8'h00, 1'b0, '0},
        '{ACT_RD_REQ,  8'h00, 1'b0, '0},
        '{ACT_DATA,    8'h81, 1'b0, '0},
        '{ACT_RD_ADDR, 8'h00, 1'b0, '0}
    };

    i2c_eeprom_style_slave_memory dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .data_in     (data_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_data   (read_data),
        .read_valid  (read_valid),
        .pointer_now (pointer_now)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("i2c_eeprom_style_slave_memory_tb: errors");
        $finish;
    end

    function automatic logic [PTR_W-1:0] ptr_bump(input logic [PTR_W-1:0] p);
        return PTR_W'((int'(p) + 1) % MEM_DEPTH);
    endfunction

    function automatic void take_start();
        if (start_armed)
        begin
            cur_ptr     = PTR_W'(int'(addr_lo) % MEM_DEPTH);
            start_armed = 1'b0;
        end
    endfunction

    function automatic event_result_t predict_event(input logic [ACT_W-1:0] act,
                                                    input logic [DATA_W-1:0] dat);
        event_result_t r;
        r = '0;
        case (act)
            ACT_WR_ADDR:
            begin
                addr_cnt    = '0;
                addr_lo     = '0;
                start_armed = 1'b0;
                cur_ptr     = '0;
            end
            ACT_DATA:
            begin
                if (addr_cnt < ADDR_BYTES)
                begin
                    // only the second address byte is kept
                    if (addr_cnt == SEEN_W'(1))
                    begin
                        addr_lo     = dat;
                        start_armed = 1'b1;
                    end
                    addr_cnt = addr_cnt + SEEN_W'(1);
                end
                else
                begin
                    take_start();
                    mem_img[cur_ptr] = dat;
                    cur_ptr          = ptr_bump(cur_ptr);
                end
            end
            ACT_RD_ADDR:
            begin
                take_start();
            end
            default:
            begin
                r.rdata  = mem_img[cur_ptr];
                r.rvalid = 1'b1;
                cur_ptr  = ptr_bump(cur_ptr);
            end
        endcase
        r.ptr = OUT_PTR_W'(cur_ptr);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (items_sent >= 600 && items_sent < 700)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    task automatic send_event(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] dat,
                              input logic typed, input event_result_t typed_res);
        int            gap;
        event_result_t r;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        data_in  <= dat;
        r = predict_event(act, dat);
        expected_q.push_back(typed ? typed_res : r);
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    task automatic send_plain(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] dat);
        send_event(act, dat, 1'b0, '0);
    endtask

    task automatic send_word_address();
        send_plain(ACT_WR_ADDR, DATA_W'($urandom));
        send_plain(ACT_DATA, DATA_W'($urandom));
        send_plain(ACT_DATA, DATA_W'($urandom));
    endtask

    function automatic int burst_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 8);
    endfunction

    task automatic check_result();
        event_result_t e;
        results_taken++;
        if (expected_q.size() == 0)
        begin
            $error("unexpected result: read_data %0h read_valid %0b pointer_now %0d",
                   read_data, read_valid, pointer_now);
            err_cnt++;
            return;
        end
        e = expected_q.pop_front();
        if (read_data !== e.rdata)
        begin
            $error("read_data: expected %0h, got %0h", e.rdata, read_data);
            err_cnt++;
        end
        if (read_valid !== e.rvalid)
        begin
            $error("read_valid: expected %0b, got %0b", e.rvalid, read_valid);
            err_cnt++;
        end
        if (pointer_now !== e.ptr)
        begin
            $error("pointer_now: expected %0d, got %0d", e.ptr, pointer_now);
            err_cnt++;
        end
    endtask

    // result side: check each transfer, then pick the stall for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            check_result();
        end
        if (!long_done && results_taken >= LONG_HOLD_AT)
        begin
            hold_left = 90;
            long_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            int r;
            out_stall <= 1'b0;
            r = $urandom_range(0, 99);
            if (results_taken >= 650 && results_taken < 750)
            begin
                stall_left = 0;
            end
            else if (r < 60)
            begin
                stall_left = 0;
            end
            else if (r < 90)
            begin
                stall_left = $urandom_range(1, 3);
            end
            else if (r < 97)
            begin
                stall_left = $urandom_range(4, 12);
            end
            else
            begin
                stall_left = $urandom_range(20, 40);
            end
        end
    end

    initial
    begin
        int  kind;
        int  n;
        bit  paused;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        action    = ACT_WR_ADDR;
        data_in   = '0;
        paused    = 1'b0;
        foreach (mem_img[i])
        begin
            mem_img[i] = '0;
        end
        cur_ptr     = '0;
        addr_cnt    = '0;
        addr_lo     = '0;
        start_armed = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            send_event(directed_rows[i].act, directed_rows[i].dat,
                       directed_rows[i].typed, directed_rows[i].exp);
        end

        while (items_sent < N_DIRECTED + N_RANDOM)
        begin
            if (!paused && items_sent >= N_DIRECTED + PAUSE_AT)
            begin
                // hold the sender until every outstanding result has drained
                paused = 1'b1;
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (expected_q.size() != 0);
            end
            kind = $urandom_range(0, 9);
            if (kind < 4)
            begin
                send_word_address();
                n = burst_len();
                repeat (n) send_plain(ACT_DATA, DATA_W'($urandom));
            end
            else if (kind < 7)
            begin
                send_word_address();
                send_plain(ACT_RD_ADDR, DATA_W'($urandom));
                n = burst_len();
                repeat (n) send_plain(ACT_RD_REQ, DATA_W'($urandom));
            end
            else if (kind == 7)
            begin
                send_plain(ACT_RD_ADDR, DATA_W'($urandom));
                n = $urandom_range(1, 6);
                repeat (n) send_plain(ACT_RD_REQ, DATA_W'($urandom));
            end
            else
            begin
                n = $urandom_range(1, 6);
                repeat (n) send_plain(ACT_W'($urandom), DATA_W'($urandom));
            end
        end
        in_valid <= 1'b0;

        while (expected_q.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
        if (err_cnt == 0)
        begin
            $display("i2c_eeprom_style_slave_memory_tb: clean");
        end
        else
        begin
            $display("i2c_eeprom_style_slave_memory_tb: errors");
        end
        $finish;
    end

endmodule
